// ===== hw/rtl/ahp_pkg.sv =====
// shared types and constants of the ax.25 header parser
package ahp_pkg;

	localparam int MAX_REPEATERS = 2;
	localparam int SLOT_W        = $clog2(MAX_REPEATERS + 2);
	localparam int CALL_LEN      = 6;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] KIND_CHAR    = 3'd0;
	localparam logic [2:0] KIND_ADDR    = 3'd1;
	localparam logic [2:0] KIND_CTRL    = 3'd2;
	localparam logic [2:0] KIND_SEQ     = 3'd3;
	localparam logic [2:0] KIND_PID     = 3'd4;
	localparam logic [2:0] KIND_PAYLOAD = 3'd5;
	localparam logic [2:0] KIND_OK      = 3'd6;
	localparam logic [2:0] KIND_ERROR   = 3'd7;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_CALLSIGN  = 2'd1;
	localparam logic [1:0] ERR_TOO_SHORT = 2'd2;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
		logic [1:0] addr_slot;
		logic [3:0] ssid_value;
		logic       was_repeated;
		logic       addr_end;
		logic [1:0] error_code;
	} res_t;

	// results caused by one byte: an optional own result and an optional outcome
	typedef struct packed {
		res_t head;
		logic head_v;
		logic tail_v;
		logic tail_ok;
	} desc_t;

endpackage

// ===== hw/rtl/ahp_front.sv =====
// front end: per-byte parsing state and result classification
module ahp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     rx_byte,
	input  logic           frame_last,
	output logic           push,
	output ahp_pkg::desc_t desc
);
	import ahp_pkg::*;

	localparam logic [2:0] PH_ADDR = 3'd0;
	localparam logic [2:0] PH_CTRL = 3'd1;
	localparam logic [2:0] PH_SEQ  = 3'd2;
	localparam logic [2:0] PH_PID  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	logic [2:0]        phase_q, phase_d;
	logic [2:0]        bia_q, bia_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic              ended_q, ended_d;
	logic [1:0]        ftype_q, ftype_d;
	logic              bad_q, bad_d;
	logic [6:0]        chr;
	logic [SLOT_W-1:0] done_cnt;
	logic              clear;

	assign chr      = rx_byte[7:1];
	assign done_cnt = (slot_q == SLOT_W'(1)) ? '0 : slot_q - SLOT_W'(1);

	always_comb begin
		phase_d     = phase_q;
		bia_d       = bia_q;
		slot_d      = slot_q;
		ended_d     = ended_q;
		ftype_d     = ftype_q;
		bad_d       = bad_q;
		clear       = 1'b0;
		desc        = '0;
		if (bad_q) begin
			clear = frame_last;
		end else begin
			unique case (phase_q)
				PH_ADDR: begin
					if (bia_q < 3'(CALL_LEN)) begin
						if (rx_byte[0]) begin
							desc.head_v          = 1'b1;
							desc.head.kind       = KIND_ERROR;
							desc.head.error_code = ERR_CALLSIGN;
							bad_d                = 1'b1;
						end else begin
							if (chr == 7'd0 || chr == 7'd32 || ended_q) begin
								ended_d = 1'b1;
							end else begin
								desc.head_v         = 1'b1;
								desc.head.kind      = KIND_CHAR;
								desc.head.value     = {1'b0, chr};
								desc.head.addr_slot = slot_q[1:0];
							end
							bia_d = bia_q + 3'd1;
						end
					end else begin
						desc.head_v            = 1'b1;
						desc.head.kind         = KIND_ADDR;
						desc.head.addr_slot    = slot_q[1:0];
						desc.head.ssid_value   = rx_byte[4:1];
						desc.head.was_repeated = rx_byte[7];
						desc.head.addr_end     = rx_byte[0];
						bia_d                  = '0;
						ended_d                = 1'b0;
						if (slot_q == '0) begin
							slot_d = SLOT_W'(1);
						end else if (rx_byte[0] || done_cnt >= SLOT_W'(MAX_REPEATERS)) begin
							phase_d = PH_CTRL;
						end else begin
							slot_d = slot_q + SLOT_W'(1);
						end
					end
				end
				PH_CTRL: begin
					desc.head_v     = 1'b1;
					desc.head.kind  = KIND_CTRL;
					desc.head.value = rx_byte;
					ftype_d         = rx_byte[0] ? rx_byte[1:0] : 2'd0;
					phase_d         = (rx_byte[1:0] == 2'd3) ? PH_PID : PH_SEQ;
				end
				PH_SEQ: begin
					desc.head_v     = 1'b1;
					desc.head.kind  = KIND_SEQ;
					desc.head.value = rx_byte;
					phase_d         = (ftype_q == 2'd0) ? PH_PID : PH_DATA;
				end
				PH_PID: begin
					desc.head_v     = 1'b1;
					desc.head.kind  = KIND_PID;
					desc.head.value = rx_byte;
					phase_d         = PH_DATA;
				end
				default: begin
					desc.head_v     = 1'b1;
					desc.head.kind  = KIND_PAYLOAD;
					desc.head.value = rx_byte;
					phase_d         = PH_DATA;
				end
			endcase
			// a bad callsign byte gives its error alone, the last byte just rearms
			if (frame_last) begin
				clear = 1'b1;
				if (!(phase_q == PH_ADDR && bia_q < 3'(CALL_LEN) && rx_byte[0])) begin
					desc.tail_v  = 1'b1;
					desc.tail_ok = (phase_d == PH_DATA);
				end
			end
		end
	end

	assign push = accept && (desc.head_v || desc.tail_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ADDR;
			bia_q   <= '0;
			slot_q  <= '0;
			ended_q <= 1'b0;
			ftype_q <= 2'd0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			if (clear) begin
				phase_q <= PH_ADDR;
				bia_q   <= '0;
				slot_q  <= '0;
				ended_q <= 1'b0;
				ftype_q <= 2'd0;
				bad_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				bia_q   <= bia_d;
				slot_q  <= slot_d;
				ended_q <= ended_d;
				ftype_q <= ftype_d;
				bad_q   <= bad_d;
			end
		end
	end

endmodule

// ===== hw/rtl/ahp_queue.sv =====
// short descriptor queue between front end and back end
module ahp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ahp_pkg::desc_t wr_desc,
	input  logic           pop,
	output ahp_pkg::desc_t rd_desc,
	output logic           empty,
	output logic           full
);
	import ahp_pkg::*;

	desc_t               entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign rd_desc = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/ahp_back.sv =====
// back end: expands descriptors into results behind an output register
module ahp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ahp_pkg::desc_t rd_desc,
	input  logic           empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output ahp_pkg::res_t  out_res,
	output logic           out_last
);
	import ahp_pkg::*;

	logic  valid_q;
	res_t  res_q;
	logic  last_q;
	logic  tail_pend_q;
	logic  tail_ok_q;
	logic  load;
	res_t  tail_res;
	res_t  queued_tail;

	assign load = !valid_q || out_ready;
	assign pop  = load && !tail_pend_q && !empty;

	always_comb begin
		tail_res             = '0;
		tail_res.kind        = tail_ok_q ? KIND_OK : KIND_ERROR;
		tail_res.error_code  = tail_ok_q ? ERR_NONE : ERR_TOO_SHORT;
		queued_tail            = '0;
		queued_tail.kind       = rd_desc.tail_ok ? KIND_OK : KIND_ERROR;
		queued_tail.error_code = rd_desc.tail_ok ? ERR_NONE : ERR_TOO_SHORT;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (tail_pend_q) begin
				res_q  <= tail_res;
				last_q <= 1'b1;
			end else if (rd_desc.head_v) begin
				res_q  <= rd_desc.head;
				last_q <= !rd_desc.tail_v;
			end else begin
				res_q  <= queued_tail;
				last_q <= 1'b1;
			end
			if (pop) begin
				tail_ok_q <= rd_desc.tail_ok;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			tail_pend_q <= 1'b0;
		end else if (load) begin
			valid_q     <= tail_pend_q || !empty;
			tail_pend_q <= pop && rd_desc.head_v && rd_desc.tail_v;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;
	assign out_last  = last_q;

endmodule

// ===== hw/rtl/ax25_header_parser_core.sv =====
// top level of the ax.25 frame header parser
//
//   channel  signals                      moves
//   in       in_valid / in_ready          one frame byte and its last-byte flag
//   out      out_valid / out_ready        one result: kind, value, address summary, error
//
// cycles: a byte transfer is taken every cycle while the descriptor queue has room;
// the front end decides all results of a byte in the cycle it is accepted
// output: one result per cycle from the output register while out_ready is high; a byte
// closing a frame with its own result yields two results; the queue holds 4 descriptors
// reset: arst_n clears the parser state, queue pointers and output valid at once
// stalls: in_ready drops only when the queue is full; out_ready low holds the result
module ax25_header_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       frame_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [7:0] value,
	output logic [1:0] addr_slot,
	output logic [3:0] ssid_value,
	output logic       was_repeated,
	output logic       addr_end,
	output logic [1:0] error_code,
	output logic       run_last
);
	import ahp_pkg::*;

	logic  accept;
	logic  push;
	logic  pop;
	logic  q_empty;
	logic  q_full;
	desc_t wr_desc;
	desc_t rd_desc;
	res_t  out_res;

	// an input transfer can happen whenever the queue can take a descriptor
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// front end: address, control and payload parsing per byte
	ahp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.frame_last (frame_last),
		.push       (push),
		.desc       (wr_desc)
	);

	// decouples byte intake from result delivery
	ahp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (wr_desc),
		.pop     (pop),
		.rd_desc (rd_desc),
		.empty   (q_empty),
		.full    (q_full)
	);

	// back end: one result per output transfer
	ahp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_desc   (rd_desc),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res),
		.out_last  (run_last)
	);

	assign kind         = out_res.kind;
	assign value        = out_res.value;
	assign addr_slot    = out_res.addr_slot;
	assign ssid_value   = out_res.ssid_value;
	assign was_repeated = out_res.was_repeated;
	assign addr_end     = out_res.addr_end;
	assign error_code   = out_res.error_code;

endmodule
